// ----- hdl/assert_macros.svh -----
// Assertion helpers shared by the sequencer modules.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression holds at every clock edge outside reset.
`define AST_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// When the antecedent holds, the consequent holds in the same cycle.
`define AST_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// When the antecedent holds, the consequent holds in the next cycle.
`define AST_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/sas_pkg.sv -----
package sas_pkg;

  localparam int MAX_FRAMES_DEF = 16;
  localparam int DELAY_BITS_DEF = 16;
  localparam int QUEUE_DEPTH    = 2;

  localparam int KIND_W     = 3;
  localparam int SEL_W      = 4;
  localparam int RAW_W      = 16;
  localparam int MAG_W      = 15;
  localparam int CNT_W      = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_COUNT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT_ENABLE = 2'd1;

  typedef enum logic [2:0] {
    OP_TICK      = 3'd0,
    OP_PLAY      = 3'd1,
    OP_PAUSE     = 3'd2,
    OP_RESTART   = 3'd3,
    OP_SELECT    = 3'd4,
    OP_WRITE     = 3'd5,
    OP_WRITE_ALL = 3'd6,
    OP_NONE      = 3'd7
  } op_t;

  typedef enum logic [2:0] {
    ST_STOPPED  = 3'd0,
    ST_START    = 3'd1,
    ST_RUNNING  = 3'd2,
    ST_CHANGE   = 3'd3,
    ST_FINISHED = 3'd4,
    ST_PAUSED   = 3'd5
  } state_t;

  // A classified command as it waits in the queue.
  typedef struct packed {
    op_t              op;
    logic [SEL_W-1:0] sel;
    logic [MAG_W-1:0] delay;
    logic             ok;
    logic             no_frames;
  } cmd_t;

  // One result word as produced by the execution side.
  typedef struct packed {
    state_t           state;
    logic [SEL_W-1:0] frame;
    logic             accepted;
    logic             no_frames_error;
  } result_t;

endpackage

// ----- hdl/sprite_animation_sequencer.sv -----
// Sprite animation frame sequencer. Each input word carries a command in in_tuser (tick, play,
// pause, restart, select frame, write one delay, write all delays) and its operands in in_tdata;
// every accepted word produces exactly one result word with the sequencer state, the current
// frame, an accepted flag for selects and delay writes, and a flag for a tick that arrives in an
// active state with no frames configured. The block sustains one word per clock cycle while
// out_tready is high: a combinational front end classifies each word against the frame count
// and places it in a two-entry queue, and the execution stage retires one command per cycle,
// when the output register is empty or being read, from the queue into a registered output,
// so a result waiting on out_tready does not stop new words being taken until the queue is
// full. An accepted word is written into the queue, and its result is then written from the
// queue into the output register, which drives out_tvalid. frame_count and repeat_enable are
// written through the cfg_ channel, which is always ready and should only be used while no
// words are in flight; a frame count is capped at the smaller of MAX_FRAMES and 31.
// The delay store is cleared by reset at once, so the block is ready for traffic once reset ends.
module sprite_animation_sequencer #(
  parameter int MAX_FRAMES = sas_pkg::MAX_FRAMES_DEF,
  parameter int DELAY_BITS = sas_pkg::DELAY_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // [3:0] frame_select, [19:4] delay_value (signed), [23:20] zero
  input  logic [23:0]                    in_tdata,
  // [2:0] kind
  input  logic [sas_pkg::KIND_W-1:0]     in_tuser,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // [2:0] anim_state, [6:3] frame_index, [7] accepted, [8] no_frames_error, [15:9] zero
  output logic [15:0]                    out_tdata,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [sas_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sas_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int FC_CAP_I = (MAX_FRAMES < 31) ? MAX_FRAMES : 31;
  localparam logic [sas_pkg::CNT_W-1:0] FC_CAP = sas_pkg::CNT_W'(FC_CAP_I);

  logic [sas_pkg::CNT_W-1:0] frame_count_r, frame_count_nxt;
  logic                      repeat_r, repeat_nxt;
  logic [sas_pkg::CNT_W-1:0] fc;

  logic             push;
  logic             pop;
  logic             q_valid;
  logic             q_full;
  sas_pkg::cmd_t    front_cmd;
  sas_pkg::cmd_t    head_cmd;
  sas_pkg::result_t res;

  // Configuration writes go straight into registers, so the channel never stalls.
  assign cfg_ready = 1'b1;

  always_comb begin
    frame_count_nxt = frame_count_r;
    repeat_nxt      = repeat_r;
    if (cfg_valid) begin
      case (cfg_index)
        sas_pkg::REG_FRAME_COUNT:   frame_count_nxt = cfg_data[sas_pkg::CNT_W-1:0];
        sas_pkg::REG_REPEAT_ENABLE: repeat_nxt      = cfg_data[0];
        default:                    frame_count_nxt = frame_count_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_count_r <= '0;
      repeat_r      <= 1'b0;
    end else begin
      frame_count_r <= frame_count_nxt;
      repeat_r      <= repeat_nxt;
    end
  end

  // Number of frames actually in use.
  assign fc = (frame_count_r > FC_CAP) ? FC_CAP : frame_count_r;

  sas_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_kind   (in_tuser),
    .in_sel    (in_tdata[3:0]),
    .in_delay  (in_tdata[19:4]),
    .fc        (fc),
    .q_full    (q_full),
    .push      (push),
    .cmd       (front_cmd)
  );

  sas_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (front_cmd),
    .pop      (pop),
    .q_valid  (q_valid),
    .q_full   (q_full),
    .head     (head_cmd)
  );

  sas_back #(
    .MAX_FRAMES (MAX_FRAMES),
    .DELAY_BITS (DELAY_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .cmd        (head_cmd),
    .pop        (pop),
    .fc         (fc),
    .repeat_en  (repeat_r),
    .out_tready (out_tready),
    .out_valid  (out_tvalid),
    .res        (res)
  );

  assign out_tdata = {7'd0, res.no_frames_error, res.accepted, res.frame, res.state};

endmodule

// ----- hdl/sas_front.sv -----
module sas_front (
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [sas_pkg::KIND_W-1:0]      in_kind,
  input  logic [sas_pkg::SEL_W-1:0]       in_sel,
  input  logic [sas_pkg::RAW_W-1:0]       in_delay,
  input  logic [sas_pkg::CNT_W-1:0]       fc,
  input  logic                            q_full,
  output logic                            push,
  output sas_pkg::cmd_t                   cmd
);

  logic neg;
  logic sel_in_range;

  assign in_tready    = !q_full;
  assign push         = in_tvalid && !q_full;
  assign neg          = in_delay[sas_pkg::RAW_W-1];
  assign sel_in_range = {1'b0, in_sel} < fc;

  always_comb begin
    cmd.op        = sas_pkg::op_t'(in_kind);
    cmd.sel       = in_sel;
    cmd.delay     = in_delay[sas_pkg::MAG_W-1:0];
    cmd.no_frames = (fc == '0);
    case (sas_pkg::op_t'(in_kind))
      sas_pkg::OP_SELECT:    cmd.ok = sel_in_range;
      sas_pkg::OP_WRITE:     cmd.ok = sel_in_range && !neg;
      sas_pkg::OP_WRITE_ALL: cmd.ok = !neg && (fc != '0);
      default:               cmd.ok = 1'b0;
    endcase
  end

endmodule

// ----- hdl/sas_queue.sv -----
`include "assert_macros.svh"

module sas_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  sas_pkg::cmd_t push_cmd,
  input  logic          pop,
  output logic          q_valid,
  output logic          q_full,
  output sas_pkg::cmd_t head
);

  localparam int DEPTH = sas_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  sas_pkg::cmd_t    slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign q_valid = (count_r != '0);
  assign q_full  = (count_r == CNT_W'(DEPTH));
  assign head    = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

  `AST_ALWAYS(a_count_bounded, count_r <= CNT_W'(DEPTH), "queue count above depth")
  `AST_IMPLY(a_pop_not_empty, pop, count_r != '0, "queue popped while empty")
  `AST_NEXT(a_fill_rises, push && !pop, count_r == $past(count_r) + 1'b1, "queue count lost a push")

endmodule

// ----- hdl/sas_back.sv -----
`include "assert_macros.svh"

module sas_back #(
  parameter int MAX_FRAMES = sas_pkg::MAX_FRAMES_DEF,
  parameter int DELAY_BITS = sas_pkg::DELAY_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      q_valid,
  input  sas_pkg::cmd_t             cmd,
  output logic                      pop,
  input  logic [sas_pkg::CNT_W-1:0] fc,
  input  logic                      repeat_en,
  input  logic                      out_tready,
  output logic                      out_valid,
  output sas_pkg::result_t          res
);

  // Only frames below the largest usable count are ever read or written.
  localparam int DEPTH = (MAX_FRAMES < 31) ? MAX_FRAMES : 31;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int DLY_W = DELAY_BITS - 1;
  localparam int WW    = DLY_W + sas_pkg::MAG_W;
  localparam int CW1   = sas_pkg::CNT_W + 1;
  localparam logic [WW-1:0] DMAX_W = WW'((64'd1 << DLY_W) - 64'd1);

  sas_pkg::state_t     state_r, state_nxt;
  logic [IDX_W-1:0]    cur_r, cur_nxt;
  logic [DELAY_BITS-1:0] el_r, el_nxt;
  logic [DLY_W-1:0]    dly_r [DEPTH];
  logic [DLY_W-1:0]    dly_nxt [DEPTH];
  logic                out_valid_r;
  sas_pkg::result_t    res_r;

  logic                  active;
  logic [DLY_W-1:0]      cur_delay;
  logic [DELAY_BITS-1:0] el_inc;
  logic                  reached;
  logic                  last;
  logic [IDX_W-1:0]      fc_last;
  logic [IDX_W-1:0]      sel_idx;
  logic [WW-1:0]         wide_delay;
  logic [WW-1:0]         clamp_w;
  logic [DLY_W-1:0]      wr_delay;
  logic                  acc;
  logic                  err;

  assign pop       = q_valid && (!out_valid_r || out_tready);
  assign out_valid = out_valid_r;
  assign res       = res_r;

  assign active     = state_r inside {[sas_pkg::ST_START:sas_pkg::ST_FINISHED]};
  assign cur_delay  = dly_r[cur_r];
  assign el_inc     = (el_r == '1) ? el_r : el_r + 1'b1;
  assign reached    = el_inc >= {1'b0, cur_delay};
  assign last       = (CW1'(cur_r) + 1'b1) >= {1'b0, fc};
  assign fc_last    = IDX_W'(fc - 1'b1);
  assign sel_idx    = IDX_W'(cmd.sel);
  assign wide_delay = WW'(cmd.delay);
  assign clamp_w    = (wide_delay > DMAX_W) ? DMAX_W : wide_delay;
  assign wr_delay   = clamp_w[DLY_W-1:0];

  // Sequencer state.
  always_comb begin
    state_nxt = state_r;
    if (pop) begin
      case (cmd.op)
        sas_pkg::OP_TICK: begin
          if (active && !cmd.no_frames) begin
            if (!reached) begin
              state_nxt = sas_pkg::ST_RUNNING;
            end else if (!last) begin
              state_nxt = sas_pkg::ST_CHANGE;
            end else if (repeat_en) begin
              state_nxt = sas_pkg::ST_FINISHED;
            end else begin
              state_nxt = sas_pkg::ST_STOPPED;
            end
          end
        end
        sas_pkg::OP_PLAY: begin
          state_nxt = (state_r == sas_pkg::ST_STOPPED) ? sas_pkg::ST_START
                                                       : sas_pkg::ST_RUNNING;
        end
        sas_pkg::OP_PAUSE:   state_nxt = sas_pkg::ST_PAUSED;
        sas_pkg::OP_RESTART: state_nxt = sas_pkg::ST_START;
        default:             state_nxt = state_r;
      endcase
    end
  end

  // Frame index, tick counter, delay store and flags.
  always_comb begin
    cur_nxt = cur_r;
    el_nxt  = el_r;
    dly_nxt = dly_r;
    acc     = 1'b0;
    err     = 1'b0;
    if (pop) begin
      case (cmd.op)
        sas_pkg::OP_TICK: begin
          if (active) begin
            if (cmd.no_frames) begin
              err = 1'b1;
            end else if (reached) begin
              el_nxt = '0;
              if (!last) begin
                cur_nxt = cur_r + 1'b1;
              end else begin
                cur_nxt = repeat_en ? '0 : fc_last;
              end
            end else begin
              el_nxt = el_inc;
            end
          end
        end
        sas_pkg::OP_RESTART: begin
          cur_nxt = '0;
          el_nxt  = '0;
        end
        sas_pkg::OP_SELECT: begin
          if (cmd.ok) begin
            cur_nxt = sel_idx;
            el_nxt  = '0;
            acc     = 1'b1;
          end
        end
        sas_pkg::OP_WRITE: begin
          if (cmd.ok) begin
            dly_nxt[sel_idx] = wr_delay;
            acc              = 1'b1;
          end
        end
        sas_pkg::OP_WRITE_ALL: begin
          if (cmd.ok) begin
            for (int i = 0; i < DEPTH; i++) begin
              if (sas_pkg::CNT_W'(i) < fc) begin
                dly_nxt[i] = wr_delay;
              end
            end
            acc = 1'b1;
          end
        end
        default: begin
          acc = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sas_pkg::ST_STOPPED;
      cur_r       <= '0;
      el_r        <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < DEPTH; i++) begin
        dly_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      cur_r   <= cur_nxt;
      el_r    <= el_nxt;
      dly_r   <= dly_nxt;
      if (pop) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      res_r.state           <= state_nxt;
      res_r.frame           <= sas_pkg::SEL_W'(cur_nxt);
      res_r.accepted        <= acc;
      res_r.no_frames_error <= err;
    end
  end

  `AST_IMPLY(a_flags_apart, out_valid_r, !(res_r.accepted && res_r.no_frames_error), "accept and error together")
  `AST_ALWAYS(a_cur_in_store, int'(cur_r) < DEPTH, "frame index outside delay store")
  `AST_NEXT(a_restart, pop && cmd.op == sas_pkg::OP_RESTART, state_r == sas_pkg::ST_START && cur_r == '0, "restart not applied")

endmodule
